// ===== hdl/ac_pkg.sv =====
// ---------------------------------------------------------------------------
// ac_pkg: shared types and constants of the Aho-Corasick byte matcher
// Request codes, store entry layouts and the queue entry between front and
// back end.
// ---------------------------------------------------------------------------
`default_nettype none
package ac_pkg;

  localparam int unsigned NODE_W = 46;
  localparam int unsigned EDGE_W = 21;

  // request codes
  localparam logic [1:0] REQ_NODE    = 2'd0;
  localparam logic [1:0] REQ_EDGE    = 2'd1;
  localparam logic [1:0] REQ_MATCH   = 2'd2;
  localparam logic [1:0] REQ_IGNORED = 2'd3;  // unused code, dropped on intake

  typedef struct packed {
    logic [12:0] fail;
    logic        has_pat;
    logic [9:0]  pat;
    logic [12:0] estart;
    logic [8:0]  etotal;
  } node_ent_t;

  typedef struct packed {
    logic [7:0]  label;
    logic [12:0] dest;
  } edge_ent_t;

  // one queued request; index and label are shared between request kinds
  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] index;
    node_ent_t   node;
    logic [7:0]  label;
    logic [12:0] dest;
    logic        last;
  } q_ent_t;

  // ASCII A-Z to lowercase
  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) r = b + 8'h20;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/aho_corasick_byte_matcher.sv =====
// ---------------------------------------------------------------------------
// aho_corasick_byte_matcher: case-insensitive Aho-Corasick byte matcher
// Loads a prebuilt automaton into node and edge RAMs and scans text bytes.
// ---------------------------------------------------------------------------
// channel | handshake          | payload
// input   | start, busy        | in_req_type .. in_text_last
// result  | out_valid (strobe) | out_found, out_pattern_hit
//
// A store write or a swallowed byte is handled at intake, in the idle state. A
// scanned byte goes through intake, a node RAM read per node visited, a check
// per in-range edge slot, a skip per out-of-range slot, a failure link per node
// whose edges run out, and the pattern check; the strobe is registered after it.
// A two-entry queue holds accepted transfers; busy is high while it is full.
// Results cannot be held off. Reset returns the walk to the root; the stores
// keep their contents.
// ---------------------------------------------------------------------------
`default_nettype none
module aho_corasick_byte_matcher
  import ac_pkg::*;
#(
  parameter int unsigned NODE_DEPTH    = 8192,
  parameter int unsigned EDGE_DEPTH    = 8192,
  parameter int unsigned PATTERN_COUNT = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [12:0] in_node_index,
  input  wire logic [12:0] in_fail_target,
  input  wire logic        in_node_has_pattern,
  input  wire logic [9:0]  in_node_pattern,
  input  wire logic [12:0] in_edge_start,
  input  wire logic [8:0]  in_edge_total,
  input  wire logic [12:0] in_edge_slot,
  input  wire logic [7:0]  in_edge_label,
  input  wire logic [12:0] in_edge_dest,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_text_last,
  output logic             out_valid,
  output logic             out_found,
  output logic [9:0]       out_pattern_hit
);

  logic   q_valid, q_pop;
  q_ent_t q_head;

  ac_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_node_index(in_node_index),
    .in_fail_target(in_fail_target), .in_node_has_pattern(in_node_has_pattern),
    .in_node_pattern(in_node_pattern), .in_edge_start(in_edge_start),
    .in_edge_total(in_edge_total), .in_edge_slot(in_edge_slot),
    .in_edge_label(in_edge_label), .in_edge_dest(in_edge_dest),
    .in_text_byte(in_text_byte), .in_text_last(in_text_last),
    .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop)
  );

  ac_back #(
    .NODE_DEPTH(NODE_DEPTH), .EDGE_DEPTH(EDGE_DEPTH), .PATTERN_COUNT(PATTERN_COUNT)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .out_valid(out_valid), .out_found(out_found), .out_pattern_hit(out_pattern_hit)
  );

endmodule
`default_nettype wire

// ===== hdl/ac_ram.sv =====
// ---------------------------------------------------------------------------
// ac_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module ac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/ac_front.sv =====
// ---------------------------------------------------------------------------
// ac_front: request intake and queue
// Accepts requests, drops unused codes, lowercases text bytes and holds them
// in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
`default_nettype none
module ac_front
  import ac_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [12:0] in_node_index,
  input  wire logic [12:0] in_fail_target,
  input  wire logic        in_node_has_pattern,
  input  wire logic [9:0]  in_node_pattern,
  input  wire logic [12:0] in_edge_start,
  input  wire logic [8:0]  in_edge_total,
  input  wire logic [12:0] in_edge_slot,
  input  wire logic [7:0]  in_edge_label,
  input  wire logic [12:0] in_edge_dest,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_text_last,
  output logic             q_valid,
  output q_ent_t           q_head,
  input  wire logic        q_pop
);

  q_ent_t     slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       acc, push;
  q_ent_t     ent;

  assign busy    = (cnt_r == 2'd2);
  assign acc     = start && !busy;
  assign push    = acc && (in_req_type != REQ_IGNORED);
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = slot_r[rp_r];

  // classify and pack the transfer
  always_comb begin
    ent.kind        = in_req_type;
    ent.index       = (in_req_type == REQ_EDGE) ? in_edge_slot : in_node_index;
    ent.node.fail   = in_fail_target;
    ent.node.has_pat = in_node_has_pattern;
    ent.node.pat    = in_node_pattern;
    ent.node.estart = in_edge_start;
    ent.node.etotal = in_edge_total;
    ent.label       = (in_req_type == REQ_MATCH) ? to_lower(in_text_byte) : in_edge_label;
    ent.dest        = in_edge_dest;
    ent.last        = in_text_last;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && q_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push)  wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= ent;
  end

endmodule
`default_nettype wire

// ===== hdl/ac_back.sv =====
// ---------------------------------------------------------------------------
// ac_back: store writes and automaton walk
// Executes queued requests: writes node and edge stores, and for text bytes
// walks edges and failure links, then reports a match, or no-match on the last byte.
// ---------------------------------------------------------------------------
`default_nettype none
module ac_back
  import ac_pkg::*;
#(
  parameter int unsigned NODE_DEPTH    = 8192,
  parameter int unsigned EDGE_DEPTH    = 8192,
  parameter int unsigned PATTERN_COUNT = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  q_ent_t          q_head,
  output logic            q_pop,
  output logic            out_valid,
  output logic            out_found,
  output logic [9:0]      out_pattern_hit
);

  localparam int unsigned NAW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
  localparam int unsigned EAW = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_NCAP = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_ECHK = 3'd4;
  localparam logic [2:0] S_PRD  = 3'd5;
  localparam logic [2:0] S_PCAP = 3'd6;

  logic [2:0]  st_r, st_nxt;
  logic [12:0] cur_r, cur_nxt;
  logic        done_r, done_nxt;
  logic [16:0] steps_r, steps_nxt;
  logic [8:0]  i_r, i_nxt;
  node_ent_t   nd_r, nd_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic        ov_r, ov_nxt, of_r, of_nxt;
  logic [9:0]  op_r, op_nxt;

  logic              n_we, e_we;
  logic [NAW-1:0]    n_waddr, n_raddr;
  logic [EAW-1:0]    e_waddr, e_raddr;
  logic [NODE_W-1:0] n_rdata;
  logic [EDGE_W-1:0] e_rdata;
  node_ent_t         n_rd;
  edge_ent_t         e_rd, e_wd;
  logic [31:0]       cur32, idx32, slot32;
  logic [13:0]       slot;
  logic              cur_ok, slot_ok;

  assign cur32   = 32'(cur_r);
  assign idx32   = 32'(q_head.index);
  assign slot    = 14'(nd_r.estart) + 14'(i_r);
  assign slot32  = 32'(slot);
  assign cur_ok  = cur32 < NODE_DEPTH;
  assign slot_ok = slot32 < EDGE_DEPTH;
  assign n_raddr = cur32[NAW-1:0];
  assign e_raddr = slot32[EAW-1:0];
  assign n_waddr = idx32[NAW-1:0];
  assign e_waddr = idx32[EAW-1:0];
  assign n_rd    = node_ent_t'(n_rdata);
  assign e_rd    = edge_ent_t'(e_rdata);
  assign e_wd.label = q_head.label;
  assign e_wd.dest  = q_head.dest;

  ac_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_node_ram (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(q_head.node),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  ac_ram #(.WIDTH(EDGE_W), .DEPTH(EDGE_DEPTH)) u_edge_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wd),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  // walk sequencer
  always_comb begin
    st_nxt    = st_r;
    cur_nxt   = cur_r;
    done_nxt  = done_r;
    steps_nxt = steps_r;
    i_nxt     = i_r;
    nd_nxt    = nd_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    ov_nxt    = 1'b0;
    of_nxt    = of_r;
    op_nxt    = op_r;
    q_pop     = 1'b0;
    n_we      = 1'b0;
    e_we      = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_head.kind)
            REQ_NODE: n_we = idx32 < NODE_DEPTH;
            REQ_EDGE: e_we = idx32 < EDGE_DEPTH;
            default: begin
              if (done_r) begin
                if (q_head.last) begin
                  done_nxt = 1'b0;
                  cur_nxt  = '0;
                end
              end else begin
                byte_nxt  = q_head.label;
                last_nxt  = q_head.last;
                steps_nxt = '0;
                st_nxt    = S_LOOK;
              end
            end
          endcase
        end
      end
      S_LOOK: st_nxt = S_NCAP;
      S_NCAP: begin
        nd_nxt = cur_ok ? n_rd : '0;
        i_nxt  = '0;
        st_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (i_r == nd_r.etotal) begin
          // no edge for this byte here
          if (cur_r == '0) begin
            st_nxt = S_PRD;
          end else if (32'(steps_r) >= NODE_DEPTH) begin
            cur_nxt = '0;
            st_nxt  = S_LOOK;
          end else begin
            cur_nxt   = nd_r.fail;
            steps_nxt = steps_r + 17'd1;
            st_nxt    = S_LOOK;
          end
        end else if (slot_ok) begin
          st_nxt = S_ECHK;
        end else begin
          i_nxt = i_r + 9'd1;
        end
      end
      S_ECHK: begin
        if (e_rd.label == byte_r) begin
          cur_nxt = e_rd.dest;
          st_nxt  = S_PRD;
        end else begin
          i_nxt  = i_r + 9'd1;
          st_nxt = S_SCAN;
        end
      end
      S_PRD: st_nxt = S_PCAP;
      S_PCAP: begin
        st_nxt = S_IDLE;
        if (cur_ok && n_rd.has_pat && (32'(n_rd.pat) < PATTERN_COUNT)) begin
          ov_nxt = 1'b1;
          of_nxt = 1'b1;
          op_nxt = n_rd.pat;
          if (last_r) cur_nxt = '0;
          else done_nxt = 1'b1;
        end else if (last_r) begin
          ov_nxt  = 1'b1;
          of_nxt  = 1'b0;
          op_nxt  = '0;
          cur_nxt = '0;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cur_r  <= '0;
      done_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cur_r  <= cur_nxt;
      done_r <= done_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steps_r <= steps_nxt;
    i_r     <= i_nxt;
    nd_r    <= nd_nxt;
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
    of_r    <= of_nxt;
    op_r    <= op_nxt;
  end

  assign out_valid       = ov_r;
  assign out_found       = of_r;
  assign out_pattern_hit = op_r;

endmodule
`default_nettype wire
